// ===== src/cmti_pkg.sv =====
`default_nettype none

package cmti_pkg;

   // Field widths of the request and result channels
   localparam int CHANNEL_W     = 16;
   localparam int NUM_CHANNELS  = 4;
   localparam int ENTRY_INDEX_W = 10;
   localparam int SAMPLE_W      = 18;
   localparam int TABLE_SIZE_W  = 11;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   // Request operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE = 1'b0;

   typedef logic [CHANNEL_W-1:0] channel_type;

   // One colour entry: index 0 red, 1 green, 2 blue, 3 alpha
   typedef channel_type [NUM_CHANNELS-1:0] rgba_type;

   localparam int RGBA_W = $bits(rgba_type);

endpackage

`default_nettype wire

// ===== src/cmti_req_if.sv =====
`default_nettype none

interface cmti_req_if;
   logic                                        valid;
   logic                                        ready;
   logic                                        operation;
   logic        [cmti_pkg::ENTRY_INDEX_W-1:0]   entry_index;
   logic        [cmti_pkg::CHANNEL_W-1:0]       red_in;
   logic        [cmti_pkg::CHANNEL_W-1:0]       green_in;
   logic        [cmti_pkg::CHANNEL_W-1:0]       blue_in;
   logic        [cmti_pkg::CHANNEL_W-1:0]       alpha_in;
   logic signed [cmti_pkg::SAMPLE_W-1:0]        sample_value;

   modport source (
      output valid, operation, entry_index, red_in, green_in, blue_in, alpha_in,
             sample_value,
      input  ready
   );

   modport sink (
      input  valid, operation, entry_index, red_in, green_in, blue_in, alpha_in,
             sample_value,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/cmti_rsp_if.sv =====
`default_nettype none

interface cmti_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cmti_pkg::CHANNEL_W-1:0]   red_out;
   logic [cmti_pkg::CHANNEL_W-1:0]   green_out;
   logic [cmti_pkg::CHANNEL_W-1:0]   blue_out;
   logic [cmti_pkg::CHANNEL_W-1:0]   alpha_out;
   logic                             table_too_small;

   modport source (
      output valid, red_out, green_out, blue_out, alpha_out, table_too_small,
      input  ready
   );

   modport sink (
      input  valid, red_out, green_out, blue_out, alpha_out, table_too_small,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/cmti_ram.sv =====
`default_nettype none

module cmti_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   output logic      [WIDTH-1:0]           rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic      [WIDTH-1:0]           rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

// ===== src/cmti_csr.sv =====
`default_nettype none

module cmti_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [cmti_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [cmti_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [cmti_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                     pready,
   output logic      [cmti_pkg::TABLE_SIZE_W-1:0]   table_size
);
   import cmti_pkg::*;

   logic [TABLE_SIZE_W-1:0] table_size_ff;
   logic [TABLE_SIZE_W-1:0] table_size_in;
   logic [REG_IDX_W-1:0]    reg_idx;
   logic                    wr_access;

   assign reg_idx   = paddr[CSR_ADDR_W-1:2];
   assign wr_access = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   // Decode the write; addresses beyond the register list are dropped
   always_comb begin
      table_size_in = table_size_ff;
      if (wr_access && (reg_idx == REG_TABLE_SIZE)) begin
         table_size_in = pwdata[TABLE_SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= '0;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_TABLE_SIZE: prdata = CSR_DATA_W'(table_size_ff);
         default:        prdata = '0;
      endcase
   end

   assign table_size = table_size_ff;

endmodule

`default_nettype wire

// ===== src/colormap_table_interpolator.sv =====
`default_nettype none

// Piecewise-linear RGBA colour table lookup.
// Channels: req_chan carries requests (valid/ready). A request with operation
// write stores one RGBA entry at entry_index and gives no result. A request
// with operation evaluate maps sample_value (signed, clamped to 0..1) through
// the table and gives exactly one result on rsp_chan.
// The csr_ APB port holds table_size at byte address 0.
// Sequence: an evaluate runs through the scale multiply, table read (through
// the registered RAM ports), blend multiply and final add, one evaluate in
// flight at a time; req_chan takes no new request until it has finished,
// while a write leaves req_chan ready for the next request.
// The result sits in an output register, so the next request is taken while
// a result waits; if rsp_chan stays stalled, the following evaluate waits in
// its last step until the register frees.
// Reset clears table_size and the control state; the table contents are not
// cleared and an entry must be written before it is read.
module colormap_table_interpolator #(
   parameter int TABLE_DEPTH   = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   cmti_req_if.sink                                req_chan,
   cmti_rsp_if.source                              rsp_chan,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [cmti_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [cmti_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [cmti_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                    csr_pready
);
   import cmti_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int NW = $clog2(TABLE_DEPTH + 1);
   localparam int VW = FRACTION_BITS + 1;
   localparam int PW = VW + NW;
   localparam int SW = PW - FRACTION_BITS;
   localparam int MW = CHANNEL_W + 1 + FRACTION_BITS + 1;
   localparam logic signed [31:0] ONE_EXT = 32'sd1 <<< FRACTION_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_ADDR,
      ST_MULT,
      ST_SUM
   } state_type;

   state_type               state_ff, state_in;
   logic [TABLE_SIZE_W-1:0] table_size;

   logic                    req_accept;
   logic                    eval_accept;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   rgba_type                wr_data;

   logic signed [31:0]      sample_ext;
   logic [VW-1:0]           v_ff, v_in;
   logic [NW-1:0]           n_ff, n_in;
   logic [NW-1:0]           nm1;
   logic                    small_ff;
   logic [PW-1:0]           prod_ff, prod_in;

   logic [SW-1:0]           sel;
   logic                    last, last_ff;
   logic [FRACTION_BITS-1:0] frac_ff;
   logic [AW-1:0]           rd_addr_a, rd_addr_b;
   rgba_type                rd_data_a, rd_data_b;

   rgba_type                a_ff;
   logic signed [MW-1:0]    blend_ff [NUM_CHANNELS];
   logic signed [MW-1:0]    blend_in [NUM_CHANNELS];

   rgba_type                sum_rgba;
   logic                    rsp_load;
   logic                    rsp_valid_ff, rsp_valid_in;
   rgba_type                rsp_rgba_ff;
   logic                    rsp_small_ff;

   // Configuration registers
   cmti_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .table_size (table_size)
   );

   // Request handshake; writes go to the table at the accepting edge, and
   // reads only happen later in the evaluate sequence, so they never collide
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign eval_accept    = req_accept && (req_chan.operation == OP_EVAL);
   assign wr_en          = req_accept && (req_chan.operation == OP_WRITE) &&
                           (32'(req_chan.entry_index) < 32'(TABLE_DEPTH));
   assign wr_addr        = AW'(req_chan.entry_index);

   always_comb begin
      wr_data    = '0;
      wr_data[0] = req_chan.red_in;
      wr_data[1] = req_chan.green_in;
      wr_data[2] = req_chan.blue_in;
      wr_data[3] = req_chan.alpha_in;
   end

   cmti_ram #(
      .WIDTH (RGBA_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // Clamp the sample to 0..1 and saturate the table size to the depth
   assign sample_ext = 32'(req_chan.sample_value);

   always_comb begin
      if (sample_ext < 32'sd0) begin
         v_in = '0;
      end else if (sample_ext > ONE_EXT) begin
         v_in = VW'(ONE_EXT);
      end else begin
         v_in = VW'(sample_ext);
      end
      if (32'(table_size) > 32'(TABLE_DEPTH)) begin
         n_in = NW'(TABLE_DEPTH);
      end else begin
         n_in = NW'(table_size);
      end
   end

   // Scale by the number of segments
   assign nm1     = n_ff - NW'(1);
   assign prod_in = PW'(v_ff) * PW'(nm1);

   // Split into entry index and fraction; pin the top of range to the last entry
   assign sel       = prod_ff[PW-1:FRACTION_BITS];
   assign last      = ((SW + 1)'(sel) + (SW + 1)'(1)) >= (SW + 1)'(n_ff);
   assign rd_addr_a = last ? AW'(nm1) : AW'(sel);
   assign rd_addr_b = AW'(sel + SW'(1));

   // Per-channel difference times fraction
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         blend_in[c] = MW'($signed({1'b0, rd_data_b[c]}) - $signed({1'b0, rd_data_a[c]})) *
                       MW'($signed({1'b0, frac_ff}));
      end
   end

   // Add the floored blend term back onto the lower entry
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         sum_rgba[c] = CHANNEL_W'((CHANNEL_W + 1)'({1'b0, a_ff[c]}) +
                                  blend_ff[c][FRACTION_BITS+CHANNEL_W:FRACTION_BITS]);
      end
   end

   // Sequencer
   assign rsp_load = (state_ff == ST_SUM) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (eval_accept) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: state_in = ST_ADDR;
         ST_ADDR: state_in = ST_MULT;
         ST_MULT: state_in = ST_SUM;
         ST_SUM: begin
            if (rsp_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (eval_accept) begin
         v_ff     <= v_in;
         n_ff     <= n_in;
         small_ff <= (n_in < NW'(2));
      end
      if (state_ff == ST_PROD) begin
         prod_ff <= prod_in;
      end
      if (state_ff == ST_ADDR) begin
         frac_ff <= prod_ff[FRACTION_BITS-1:0];
         last_ff <= last;
      end
      if (state_ff == ST_MULT) begin
         a_ff <= rd_data_a;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            blend_ff[c] <= blend_in[c];
         end
      end
      if (rsp_load) begin
         rsp_small_ff <= small_ff;
         if (small_ff) begin
            rsp_rgba_ff <= '0;
         end else if (last_ff) begin
            rsp_rgba_ff <= a_ff;
         end else begin
            rsp_rgba_ff <= sum_rgba;
         end
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.red_out         = rsp_rgba_ff[0];
   assign rsp_chan.green_out       = rsp_rgba_ff[1];
   assign rsp_chan.blue_out        = rsp_rgba_ff[2];
   assign rsp_chan.alpha_out       = rsp_rgba_ff[3];
   assign rsp_chan.table_too_small = rsp_small_ff;

   // An accepted evaluate starts the sequence
   a_eval_starts: assert property (@(posedge clock) disable iff (reset)
      eval_accept |=> state_ff == ST_PROD)
      else $error("evaluate request did not start the sequence");

   // A new result only comes out of the final step
   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !$past(rsp_chan.valid)) |-> $past(state_ff) == ST_SUM)
      else $error("result raised outside the final step");

   // A small-table result carries zero colour
   a_small_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.table_too_small) |->
         (rsp_chan.red_out == '0 && rsp_chan.green_out == '0 &&
          rsp_chan.blue_out == '0 && rsp_chan.alpha_out == '0))
      else $error("small-table result with non-zero colour");

   // An interpolating read stays below the last entry in use
   a_sel_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADDR && !last && !small_ff) |-> (SW + 1)'(sel) < (SW + 1)'(nm1))
      else $error("interpolation index beyond the last entry");

endmodule

`default_nettype wire
